// ----- design/elevator_hall_call_scheduler_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ELEVATOR_HALL_CALL_SCHEDULER_MACROS_SVH
`define ELEVATOR_HALL_CALL_SCHEDULER_MACROS_SVH

// Property checked at every edge outside reset.
`define EHCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked at every edge, reset included.
`define EHCS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ----- design/ehcs_pkg.sv -----
package ehcs_pkg;

   localparam int FLOOR_W = 4;
   localparam int FLOORS  = 1 << FLOOR_W;
   localparam int HEAD_W  = 2;

   localparam logic [FLOOR_W-1:0] FLOOR_MAX = FLOOR_W'(FLOORS - 1);
   localparam logic [FLOOR_W-1:0] FLOOR_MIN = '0;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);
   localparam logic [FLOOR_W-1:0] TOP_RESET = FLOOR_MAX;
   localparam logic [FLOOR_W-1:0] BOTTOM_RESET = FLOOR_MIN;

   localparam logic [HEAD_W-1:0] HEAD_NONE = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd2;

   localparam logic ACTION_CALL = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic CALL_UP   = 1'b0;
   localparam logic CALL_DOWN = 1'b1;

   localparam logic CSR_TOP_FLOOR    = 1'b0;
   localparam logic CSR_BOTTOM_FLOOR = 1'b1;

   typedef logic [FLOORS-1:0] floor_map_type;

endpackage

// ----- design/elevator_hall_call_scheduler.sv -----
// A request beat moves from the input register to the response register.
// Throughput: one item per cycle unless the response side stalls; the input register
// and the response register form a two-stage pipeline, and all scheduling for an item
// is combinational against the call maps, so items may follow back to back.
// Reset (synchronous, active high): call maps cleared, car at floor 1, heading none,
// top floor 15, bottom floor 0, both pipeline stages empty.
module elevator_hall_call_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [ehcs_pkg::FLOOR_W-1:0]   req_call_floor,
   input  logic                           req_call_heading,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ehcs_pkg::FLOOR_W-1:0]   rsp_car_floor,
   output logic [ehcs_pkg::HEAD_W-1:0]    rsp_car_heading,
   output logic                           rsp_call_accepted,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [ehcs_pkg::FLOOR_W-1:0]   csr_wdata
);
   import ehcs_pkg::*;

   logic                 in_valid_ff;
   logic                 in_action_ff;
   logic [FLOOR_W-1:0]   in_floor_ff;
   logic                 in_dir_ff;

   logic [FLOOR_W-1:0]   top_ff;
   logic [FLOOR_W-1:0]   bottom_ff;

   floor_map_type        up_ff, up_in;
   floor_map_type        down_ff, down_in;
   logic [FLOOR_W-1:0]   floor_ff, floor_in;
   logic [HEAD_W-1:0]    heading_ff, heading_in;

   logic                 out_valid_ff;
   logic [FLOOR_W-1:0]   out_floor_ff;
   logic [HEAD_W-1:0]    out_heading_ff;
   logic                 out_accepted_ff;

   logic                 advance;
   logic                 fire;
   logic                 accepted;
   floor_map_type        bounds, gt_mask, lt_mask, pend;
   logic                 above, below;
   logic                 found;
   logic [FLOOR_W-1:0]   low_idx;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign csr_ready = !reset;

   assign rsp_valid         = out_valid_ff;
   assign rsp_car_floor     = out_floor_ff;
   assign rsp_car_heading   = out_heading_ff;
   assign rsp_call_accepted = out_accepted_ff;

   always_comb begin
      // above looks up to the top bound only, below down to the bottom bound only
      for (int i = 0; i < FLOORS; i++) begin
         bounds[i]  = (FLOOR_W'(i) >= bottom_ff) && (FLOOR_W'(i) <= top_ff);
         gt_mask[i] = (FLOOR_W'(i) > floor_ff) && (FLOOR_W'(i) <= top_ff);
         lt_mask[i] = (FLOOR_W'(i) < floor_ff) && (FLOOR_W'(i) >= bottom_ff);
      end
      above = |((up_ff | down_ff) & gt_mask);
      below = |((up_ff | down_ff) & lt_mask);

      up_in      = up_ff;
      down_in    = down_ff;
      floor_in   = floor_ff;
      heading_in = heading_ff;
      accepted   = 1'b0;

      if (in_action_ff == ACTION_CALL) begin
         if ((in_floor_ff <= top_ff) && (in_floor_ff >= bottom_ff)) begin
            accepted = 1'b1;
            if (in_dir_ff == CALL_UP) begin
               up_in[in_floor_ff] = 1'b1;
            end else begin
               down_in[in_floor_ff] = 1'b1;
            end
         end
      end else begin
         unique case (heading_ff)
            HEAD_UP: begin
               up_in[floor_ff] = 1'b0;
               if (!above) begin
                  down_in[floor_ff] = 1'b0;
                  heading_in = below ? HEAD_DOWN : HEAD_NONE;
               end
            end
            HEAD_DOWN: begin
               down_in[floor_ff] = 1'b0;
               if (!below) begin
                  up_in[floor_ff] = 1'b0;
                  heading_in = above ? HEAD_UP : HEAD_NONE;
               end
            end
            default: begin
               // parked: board a call at the car's own floor, up first
               heading_in = HEAD_NONE;
               if (up_ff[floor_ff]) begin
                  heading_in = HEAD_UP;
                  up_in[floor_ff] = 1'b0;
               end else if (down_ff[floor_ff]) begin
                  heading_in = HEAD_DOWN;
                  down_in[floor_ff] = 1'b0;
               end
            end
         endcase
      end

      // lowest pending call within bounds
      pend    = (up_in | down_in) & bounds;
      found   = 1'b0;
      low_idx = '0;
      for (int i = FLOORS - 1; i >= 0; i--) begin
         if (pend[i]) begin
            found   = 1'b1;
            low_idx = FLOOR_W'(i);
         end
      end

      if (in_action_ff == ACTION_TICK) begin
         if ((heading_in == HEAD_NONE) && found) begin
            heading_in = (low_idx > floor_ff) ? HEAD_UP : HEAD_DOWN;
         end
         // hold at the served bounds and at the ends of the shaft
         if (heading_in == HEAD_UP) begin
            if ((floor_ff < top_ff) && (floor_ff != FLOOR_MAX)) begin
               floor_in = floor_ff + FLOOR_W'(1);
            end
         end else if (heading_in == HEAD_DOWN) begin
            if ((floor_ff > bottom_ff) && (floor_ff != FLOOR_MIN)) begin
               floor_in = floor_ff - FLOOR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         top_ff       <= TOP_RESET;
         bottom_ff    <= BOTTOM_RESET;
         up_ff        <= '0;
         down_ff      <= '0;
         floor_ff     <= FLOOR_RESET;
         heading_ff   <= HEAD_NONE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            up_ff      <= up_in;
            down_ff    <= down_in;
            floor_ff   <= floor_in;
            heading_ff <= heading_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOP_FLOOR) begin
               top_ff <= csr_wdata;
            end else begin
               bottom_ff <= csr_wdata;
            end
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_floor_ff  <= req_call_floor;
         in_dir_ff    <= req_call_heading;
      end
      if (fire) begin
         out_floor_ff    <= floor_in;
         out_heading_ff  <= heading_in;
         out_accepted_ff <= accepted;
      end
   end

endmodule

// ----- design/ehcs_checker.sv -----
`include "elevator_hall_call_scheduler_macros.svh"

module ehcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ehcs_pkg::FLOOR_W-1:0]   rsp_car_floor,
   input logic [ehcs_pkg::HEAD_W-1:0]    rsp_car_heading,
   input logic                           rsp_call_accepted
);
   import ehcs_pkg::*;

   logic [FLOOR_W-1:0]        last_floor_ff;
   logic                      step_ok;
   logic [FLOOR_W+HEAD_W:0]   rsp_payload;

   // track the floor of the last delivered beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_floor_ff <= FLOOR_RESET;
      end else if (rsp_valid && rsp_ready) begin
         last_floor_ff <= rsp_car_floor;
      end
   end

   assign step_ok = (rsp_car_floor == last_floor_ff)
                 || (rsp_car_floor == last_floor_ff + FLOOR_W'(1))
                 || (last_floor_ff == rsp_car_floor + FLOOR_W'(1));
   assign rsp_payload = {rsp_car_floor, rsp_car_heading, rsp_call_accepted};

   `EHCS_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)
   `EHCS_ASSERT(a_heading_legal, clock, reset, rsp_valid |-> (rsp_car_heading <= HEAD_DOWN))
   `EHCS_ASSERT(a_one_floor_step, clock, reset, rsp_valid |-> step_ok)
   `EHCS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))

endmodule

bind elevator_hall_call_scheduler ehcs_checker u_ehcs_checker (.*);
